@@ src/sfa_pkg.sv @@
package sfa_pkg;

	// op field codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_ACCUM = 1'b1;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic              op;
		logic [3:0]        segment;
		logic [7:0]        breakpoint_slot;
		logic signed [31:0] value;
		logic [7:0]        symbol;
		logic [3:0]        symbol_bits;
		logic              final_segment;
	} sfa_in_t;

	typedef struct packed {
		logic [63:0] lower_bound;
		logic        saturated;
	} sfa_out_t;

	// what the back end does with a queued word
	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_WRITE,
		KIND_ACCUM
	} sfa_kind_t;

	typedef struct packed {
		sfa_kind_t kind;
		logic      weight2;
		logic      final_seg;
		logic      lo_inf;
		logic      hi_inf;
	} sfa_ctl_t;

endpackage

@@ src/sfa_front.sv @@
module sfa_front import sfa_pkg::*; #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SYMBOL_BITS  = 8,
	parameter int SEG_W        = 4,
	parameter int ADDR_W       = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  sfa_in_t            in_word,
	output sfa_ctl_t           ctl,
	output logic [ADDR_W-1:0]  addr_a,
	output logic [ADDR_W-1:0]  addr_b,
	output logic [31:0]        value
);

	localparam int IDX_W   = SYMBOL_BITS;
	localparam int ROW_LEN = (1 << SYMBOL_BITS) - 1;

	logic             mode_q;
	logic [3:0]       bits_sat;
	logic [3:0]       shift;
	logic [7:0]       sym_m;
	logic [7:0]       lo8;
	logic [7:0]       hi8;
	logic [IDX_W-1:0] lo_idx;
	logic [IDX_W-1:0] hi_idx;
	logic [SEG_W-1:0] row;
	logic             seg_ok;
	logic             slot_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// symbol -> breakpoint interval indexes at full cardinality
	always_comb begin
		bits_sat = (int'(in_word.symbol_bits) > SYMBOL_BITS) ? 4'(SYMBOL_BITS)
		                                                      : in_word.symbol_bits;
		shift    = 4'(SYMBOL_BITS) - bits_sat;
		sym_m    = in_word.symbol & ~(8'hFF << bits_sat);
		lo8      = sym_m << shift;
		hi8      = lo8 | ~(8'hFF << shift);
		lo_idx   = lo8[IDX_W-1:0];
		hi_idx   = hi8[IDX_W-1:0];
	end

	assign seg_ok  = int'(in_word.segment) < MAX_SEGMENTS;
	assign slot_ok = int'(in_word.breakpoint_slot) < ROW_LEN;
	assign row     = SEG_W'(in_word.segment);

	always_comb begin
		ctl.lo_inf    = (lo_idx == '0);
		ctl.hi_inf    = &hi_idx;
		ctl.weight2   = !(!mode_q && in_word.segment == 4'd0);
		ctl.final_seg = (in_word.op == OP_ACCUM) && in_word.final_segment;
		if (in_word.op == OP_WRITE) begin
			ctl.kind = (seg_ok && slot_ok) ? KIND_WRITE : KIND_PASS;
			addr_a   = {row, in_word.breakpoint_slot[IDX_W-1:0]};
		end else begin
			// segment 1 is skipped in unnormalized mode
			ctl.kind = (seg_ok && !(!mode_q && in_word.segment == 4'd1)) ? KIND_ACCUM
			                                                           : KIND_PASS;
			addr_a   = {row, IDX_W'(lo_idx - IDX_W'(1))};
		end
		addr_b = {row, hi_idx};
		value  = in_word.value;
	end

endmodule

@@ src/sfa_queue.sv @@
module sfa_queue #(
	parameter int W     = 64,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = slot_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(tail_q + 1'b1);
			end
			if (pop) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(head_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

@@ src/sfa_back.sv @@
module sfa_back import sfa_pkg::*; #(
	parameter int ADDR_W = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  sfa_ctl_t          ctl,
	input  logic [ADDR_W-1:0] addr_a,
	input  logic [ADDR_W-1:0] addr_b,
	input  logic [31:0]       value,
	output logic              out_valid,
	input  logic              out_stall,
	output sfa_out_t          out_word
);

	logic [31:0] mem [2**ADDR_W];

	logic        adv;
	logic        v_s1, v_s2, v_s3;
	sfa_ctl_t    ctl_s1, ctl_s2, ctl_s3;
	logic [31:0] coef_s1;
	logic [31:0] rd_lo_s1, rd_hi_s1;
	logic [31:0] gap_s2;
	logic [63:0] sq_s3;
	logic [63:0] sum_q;
	logic        ovf_q;
	logic        out_valid_q;
	sfa_out_t    out_q;

	logic [32:0] d_lo, d_hi;
	logic [31:0] gap;
	logic [64:0] term;
	logic [64:0] sum65;
	logic        add_sat;
	logic [63:0] new_sum;
	logic        new_ovf;

	// whole back end moves unless a result is parked and stalled
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;

	// s1: table write on a write word, and two reads
	always_ff @(posedge clk) begin
		if (adv) begin
			if (q_pop && ctl.kind == KIND_WRITE) begin
				mem[addr_a] <= value;
			end
			rd_lo_s1 <= mem[addr_a];
			rd_hi_s1 <= mem[addr_b];
			ctl_s1   <= ctl;
			coef_s1  <= value;
		end
	end

	// s2: distance to the interval
	always_comb begin
		d_lo = {rd_lo_s1[31], rd_lo_s1} - {coef_s1[31], coef_s1};
		d_hi = {coef_s1[31], coef_s1} - {rd_hi_s1[31], rd_hi_s1};
		if (!ctl_s1.lo_inf && !d_lo[32] && d_lo != '0) begin
			gap = d_lo[31:0];
		end else if (!ctl_s1.hi_inf && !d_hi[32] && d_hi != '0) begin
			gap = d_hi[31:0];
		end else begin
			gap = '0;
		end
	end

	// s4: weight and saturating add
	always_comb begin
		term    = ctl_s3.weight2 ? {sq_s3, 1'b0} : {1'b0, sq_s3};
		sum65   = {1'b0, sum_q} + term;
		// a doubled square past 64 bits clips on its own
		add_sat = sum65[64] | term[64];
		if (ctl_s3.kind == KIND_ACCUM) begin
			new_sum = add_sat ? '1 : sum65[63:0];
			new_ovf = ovf_q | add_sat;
		end else begin
			new_sum = sum_q;
			new_ovf = ovf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= ctl_s1;
			gap_s2 <= gap;
			ctl_s3 <= ctl_s2;
			sq_s3  <= gap_s2 * gap_s2;
			if (v_s3 && ctl_s3.final_seg) begin
				out_q.lower_bound <= new_sum;
				out_q.saturated   <= new_ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && ctl_s3.final_seg;
			if (v_s3) begin
				if (ctl_s3.final_seg) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= new_sum;
					ovf_q <= new_ovf;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

@@ src/sfa_word_lower_bound.sv @@
// Lower-bound distance between query coefficients and a symbolic word.
// in channel (in_valid/in_stall/in_word): one word per cycle while in_stall
//   is low. op 0 writes a breakpoint into the per-segment table; op 1 adds
//   one segment's weighted squared gap to the running sum. A word is taken
//   when in_valid is high and in_stall is low.
// out channel (out_valid/out_stall/out_word): one result per op 1 word that
//   has final_segment set; held stable while out_stall is high.
// cfg_we/cfg_wdata: write normalized_mode; only while the block is idle.
// Throughput: one word per cycle while neither stall holds the flow, set by
//   the two-read-port breakpoint memory and the back end's single 32x32 multiplier.
// Path: after the final segment is accepted it moves through the queue, table read,
//   gap, square and accumulate stages into the output register, which drives out_valid.
// Stall: the back end freezes while a result waits under out_stall; the
//   front keeps taking words until the 4-deep queue is full, then raises
//   in_stall.
// Reset: running sum and overflow flag clear, normalized_mode = 1, queue
//   empties. The breakpoint table is not cleared; write an entry before use.
module sfa_word_lower_bound import sfa_pkg::*; #(
	parameter int MAX_SEGMENTS = 16,
	parameter int SYMBOL_BITS  = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	input  logic     in_valid,
	output logic     in_stall,
	input  sfa_in_t  in_word,
	output logic     out_valid,
	input  logic     out_stall,
	output sfa_out_t out_word
);

	localparam int SEG_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int ADDR_W = SEG_W + SYMBOL_BITS;
	localparam int Q_W    = $bits(sfa_ctl_t) + 2 * ADDR_W + 32;

	sfa_ctl_t          f_ctl, b_ctl;
	logic [ADDR_W-1:0] f_addr_a, f_addr_b, b_addr_a, b_addr_b;
	logic [31:0]       f_value, b_value;
	logic [Q_W-1:0]    q_wdata, q_rdata;
	logic              q_push, q_pop, q_full, q_valid;

	// front: classify the word and form table addresses
	sfa_front #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.SYMBOL_BITS  (SYMBOL_BITS),
		.SEG_W        (SEG_W),
		.ADDR_W       (ADDR_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_word   (in_word),
		.ctl       (f_ctl),
		.addr_a    (f_addr_a),
		.addr_b    (f_addr_b),
		.value     (f_value)
	);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_wdata  = {f_ctl, f_addr_a, f_addr_b, f_value};

	sfa_queue #(
		.W     (Q_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_valid)
	);

	assign {b_ctl, b_addr_a, b_addr_b, b_value} = q_rdata;

	// back: table access, gap, square, saturating sum, result register
	sfa_back #(
		.ADDR_W (ADDR_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.ctl       (b_ctl),
		.addr_a    (b_addr_a),
		.addr_b    (b_addr_b),
		.value     (b_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule
